// ===== sv/velocity_pi_with_filtered_error_defines.svh =====
// Assertion macros for the velocity loop checker file.
// Holds no logic; included by vpf_monitor, the module that carries the assertions.
`ifndef VELOCITY_PI_WITH_FILTERED_ERROR_DEFINES_SVH
`define VELOCITY_PI_WITH_FILTERED_ERROR_DEFINES_SVH

// Next-cycle implication, ignored while reset is asserted.
`define VPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define VPF_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/vpf_pkg.sv =====
// Shared types and constants for the velocity PI loop.
// No dependencies; used by every module of the block but vpf_monitor.
`timescale 1ns / 1ps
`default_nettype none

package vpf_pkg;

    // Field and register widths.
    localparam int SPEED_W   = 16;
    localparam int ROLL_W    = 12;
    localparam int ERR_W     = 18;
    localparam int INTEG_W   = 16;
    localparam int GAIN_W    = 24;
    localparam int LIMIT_W   = 15;
    localparam int TILT_W    = 11;
    localparam int DRIVE_W   = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 24;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_LIMIT     = 2'd3;

    // Register reset values.
    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST      = 24'd209715;
    localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST     = 24'd1049;
    localparam logic [LIMIT_W-1:0] INTEGRAL_LIMIT_RST = 15'd10000;
    localparam logic [TILT_W-1:0]  TILT_LIMIT_RST     = 11'd400;

    // Low-pass filter weights; they sum to 2^FILT_SHIFT.
    localparam int               FILT_SHIFT = 16;
    localparam logic [13:0]      FILT_NEW_W = 14'd13107;
    localparam logic [15:0]      FILT_OLD_W = 16'd52429;
    localparam int               FSUM_W     = 36;
    localparam logic [FSUM_W-1:0] FILT_ROUND = FSUM_W'((64'd1 << FILT_SHIFT) - 64'd1);

    // Gain fixed point and the width of the summed gain products.
    localparam int                GAIN_FRAC_BITS = 20;
    localparam int                PROD_W         = 44;
    localparam logic [PROD_W-1:0] GAIN_ROUND =
        PROD_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    // Configuration register file.
    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [LIMIT_W-1:0] integral_limit;
        logic [TILT_W-1:0]  tilt_limit;
    } t_cfg;

    // One classified sample waiting for the back end.
    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic                    roll_out;
    } t_job;

endpackage

`default_nettype wire

// ===== sv/velocity_pi_with_filtered_error.sv =====
// Top level of the velocity PI loop: configuration registers and wiring.
// Depends on vpf_pkg, vpf_front, vpf_fifo and vpf_back.
//
//   Channel   Direction  Handshake                  Payload
//   in        input      i_in_valid / o_in_stall    left, right, target speed, roll
//   out       output     o_out_valid / i_out_stall  drive_out
//   cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// The back end's sequencer works through each sample in steps (filter multiply,
// filter sum, integral clamp with the proportional product, integral product,
// output load) and, when busy, takes a sample only as it loads the last result.
// A two-entry queue takes samples while the sequencer is busy.
// Reset is synchronous and active low and clears the loop state to zero.
// A stalled result holds in the output register; the sequencer waits for it.
`timescale 1ns / 1ps
`default_nettype none

module velocity_pi_with_filtered_error (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire logic signed [vpf_pkg::SPEED_W-1:0]     i_left_speed,
    input  wire logic signed [vpf_pkg::SPEED_W-1:0]     i_right_speed,
    input  wire logic signed [vpf_pkg::SPEED_W-1:0]     i_target_speed,
    input  wire logic signed [vpf_pkg::ROLL_W-1:0]      i_roll_tenths,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic signed [vpf_pkg::DRIVE_W-1:0]          o_drive_out,
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic        [vpf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic        [vpf_pkg::CFG_DAT_W-1:0]   i_cfg_data
);

    vpf_pkg::t_cfg r_cfg;
    vpf_pkg::t_job w_front_job;
    vpf_pkg::t_job w_head_job;
    logic          w_push;
    logic          w_pop;
    logic          w_full;
    logic          w_head_valid;

    assign o_cfg_ready = 1'b1;

    // Configuration register file; each write is masked to its register width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain      <= vpf_pkg::PROP_GAIN_RST;
            r_cfg.integ_gain     <= vpf_pkg::INTEG_GAIN_RST;
            r_cfg.integral_limit <= vpf_pkg::INTEGRAL_LIMIT_RST;
            r_cfg.tilt_limit     <= vpf_pkg::TILT_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                vpf_pkg::CFG_PROP_GAIN: begin
                    r_cfg.prop_gain <= i_cfg_data[vpf_pkg::GAIN_W-1:0];
                end
                vpf_pkg::CFG_INTEG_GAIN: begin
                    r_cfg.integ_gain <= i_cfg_data[vpf_pkg::GAIN_W-1:0];
                end
                vpf_pkg::CFG_INTEGRAL_LIMIT: begin
                    r_cfg.integral_limit <= i_cfg_data[vpf_pkg::LIMIT_W-1:0];
                end
                vpf_pkg::CFG_TILT_LIMIT: begin
                    r_cfg.tilt_limit <= i_cfg_data[vpf_pkg::TILT_W-1:0];
                end
            endcase
        end
    end

    // Front end classifies each sample.
    vpf_front u_front (
        .i_in_valid     (i_in_valid),
        .i_left_speed   (i_left_speed),
        .i_right_speed  (i_right_speed),
        .i_target_speed (i_target_speed),
        .i_roll_tenths  (i_roll_tenths),
        .i_tilt_limit   (r_cfg.tilt_limit),
        .i_queue_full   (w_full),
        .o_in_stall     (o_in_stall),
        .o_push         (w_push),
        .o_job          (w_front_job)
    );

    // Queue decouples the front from the sequencer.
    vpf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_head_valid),
        .o_job   (w_head_job)
    );

    // Back end runs the loop arithmetic.
    vpf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (w_head_valid),
        .i_job       (w_head_job),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_drive_out (o_drive_out)
    );

endmodule

`default_nettype wire

// ===== sv/vpf_front.sv =====
// Front end: accepts samples, forms the speed error and the tilt flag.
// Depends on vpf_pkg; feeds vpf_fifo.
`timescale 1ns / 1ps
`default_nettype none

module vpf_front (
    input  wire logic                                    i_in_valid,
    input  wire logic signed [vpf_pkg::SPEED_W-1:0]      i_left_speed,
    input  wire logic signed [vpf_pkg::SPEED_W-1:0]      i_right_speed,
    input  wire logic signed [vpf_pkg::SPEED_W-1:0]      i_target_speed,
    input  wire logic signed [vpf_pkg::ROLL_W-1:0]       i_roll_tenths,
    input  wire logic        [vpf_pkg::TILT_W-1:0]       i_tilt_limit,
    input  wire logic                                    i_queue_full,
    output logic                                         o_in_stall,
    output logic                                         o_push,
    output vpf_pkg::t_job                                o_job
);

    logic signed [vpf_pkg::ROLL_W:0] w_roll;
    logic signed [vpf_pkg::ROLL_W:0] w_lim_pos;
    logic signed [vpf_pkg::ROLL_W:0] w_lim_neg;

    // Error is left plus right minus target, kept at full precision.
    // Roll outside the symmetric tilt window clears the integral later.
    always_comb begin
        o_job.err = vpf_pkg::ERR_W'(i_left_speed) + vpf_pkg::ERR_W'(i_right_speed)
                  - vpf_pkg::ERR_W'(i_target_speed);
        w_roll         = {i_roll_tenths[vpf_pkg::ROLL_W-1], i_roll_tenths};
        w_lim_pos      = $signed({2'b00, i_tilt_limit});
        w_lim_neg      = -w_lim_pos;
        o_job.roll_out = (w_roll > w_lim_pos) || (w_roll < w_lim_neg);
    end

    // A valid sample transfers whenever the queue has room.
    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

endmodule

`default_nettype wire

// ===== sv/vpf_fifo.sv =====
// Short queue of classified samples between front and back.
// Depends on vpf_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module vpf_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire vpf_pkg::t_job i_job,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_valid,
    output vpf_pkg::t_job      o_job
);

    vpf_pkg::t_job                       r_mem [vpf_pkg::QUEUE_DEPTH];
    logic [vpf_pkg::QUEUE_PTR_W-1:0]     r_wr_ptr;
    logic [vpf_pkg::QUEUE_PTR_W-1:0]     r_rd_ptr;
    logic [vpf_pkg::QUEUE_CNT_W-1:0]     r_count;
    logic [vpf_pkg::QUEUE_CNT_W-1:0]     n_count;

    assign o_full  = (r_count == vpf_pkg::QUEUE_CNT_W'(vpf_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    // Occupancy follows pushes and pops.
    always_comb begin
        n_count = r_count;
        if (i_push && !(i_pop && o_valid)) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop && o_valid) begin
            n_count = r_count - 1'b1;
        end
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop && o_valid) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ===== sv/vpf_back.sv =====
// Back end: filter, clamped integral, gain products and the output register.
// Depends on vpf_pkg; pops samples from vpf_fifo.
`timescale 1ns / 1ps
`default_nettype none

module vpf_back (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire vpf_pkg::t_cfg                          i_cfg,
    input  wire logic                                   i_job_valid,
    input  wire vpf_pkg::t_job                          i_job,
    output logic                                        o_pop,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic signed [vpf_pkg::DRIVE_W-1:0]          o_drive_out
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FILT  = 3'd1;
    localparam logic [2:0] ST_INTEG = 3'd2;
    localparam logic [2:0] ST_IGAIN = 3'd3;
    localparam logic [2:0] ST_SUM   = 3'd4;

    localparam logic signed [vpf_pkg::PROD_W-1:0] DRIVE_MAX =
        vpf_pkg::PROD_W'(64'sd8388607);
    localparam logic signed [vpf_pkg::PROD_W-1:0] DRIVE_MIN =
        vpf_pkg::PROD_W'(-64'sd8388608);

    logic [2:0]                                r_state;
    logic [2:0]                                n_state;
    logic                                      r_out_valid;
    logic                                      n_out_valid;
    logic signed [vpf_pkg::ERR_W-1:0]          r_filt;
    logic signed [vpf_pkg::INTEG_W-1:0]        r_integ;
    logic signed [vpf_pkg::INTEG_W-1:0]        r_ival;
    logic                                      r_roll_out;
    logic signed [32:0]                        r_p_new;
    logic signed [34:0]                        r_p_old;
    logic signed [42:0]                        r_pprod;
    logic signed [40:0]                        r_iprod;
    logic signed [vpf_pkg::DRIVE_W-1:0]        r_drive;

    logic                                      w_out_free;
    logic                                      w_take;
    logic                                      w_load_out;
    logic signed [32:0]                        w_p_new;
    logic signed [34:0]                        w_p_old;
    logic signed [vpf_pkg::FSUM_W-1:0]         w_fsum;
    logic signed [vpf_pkg::FSUM_W-1:0]         w_fbias;
    logic signed [vpf_pkg::ERR_W-1:0]          w_filt;
    logic signed [vpf_pkg::ERR_W:0]            w_isum;
    logic signed [vpf_pkg::ERR_W:0]            w_lim_pos;
    logic signed [vpf_pkg::ERR_W:0]            w_lim_neg;
    logic signed [vpf_pkg::INTEG_W-1:0]        w_iclamp;
    logic signed [vpf_pkg::PROD_W-1:0]         w_total;
    logic signed [vpf_pkg::PROD_W-1:0]         w_tbias;
    logic signed [vpf_pkg::PROD_W-1:0]         w_shift;
    logic signed [vpf_pkg::DRIVE_W-1:0]        w_drive;

    // The output register frees up when its result transfers.
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_load_out  = (r_state == ST_SUM) && w_out_free;
    assign w_take      = i_job_valid
                       && ((r_state == ST_IDLE) || w_load_out);
    assign o_pop       = w_take;
    assign o_out_valid = r_out_valid;
    assign o_drive_out = r_drive;

    // Filter weight products for the sample at the queue head.
    always_comb begin
        w_p_new = $signed({1'b0, vpf_pkg::FILT_NEW_W}) * i_job.err;
        w_p_old = $signed({1'b0, vpf_pkg::FILT_OLD_W}) * r_filt;
    end

    // Weighted sum divided by 2^16, truncating toward zero.
    always_comb begin
        w_fsum  = vpf_pkg::FSUM_W'(r_p_new) + vpf_pkg::FSUM_W'(r_p_old);
        w_fbias = w_fsum + (w_fsum[vpf_pkg::FSUM_W-1] ? vpf_pkg::FILT_ROUND : '0);
        w_filt  = w_fbias[vpf_pkg::FILT_SHIFT +: vpf_pkg::ERR_W];
    end

    // Integral plus filtered error, clamped to the symmetric limit.
    always_comb begin
        w_isum    = (vpf_pkg::ERR_W+1)'(r_integ) + (vpf_pkg::ERR_W+1)'(r_filt);
        w_lim_pos = $signed({4'b0000, i_cfg.integral_limit});
        w_lim_neg = -w_lim_pos;
        priority if (w_isum > w_lim_pos) begin
            w_iclamp = w_lim_pos[vpf_pkg::INTEG_W-1:0];
        end else if (w_isum < w_lim_neg) begin
            w_iclamp = w_lim_neg[vpf_pkg::INTEG_W-1:0];
        end else begin
            w_iclamp = w_isum[vpf_pkg::INTEG_W-1:0];
        end
    end

    // Drive: gain products summed, truncated toward zero, then saturated.
    always_comb begin
        w_total = vpf_pkg::PROD_W'(r_pprod) + vpf_pkg::PROD_W'(r_iprod);
        w_tbias = w_total + (w_total[vpf_pkg::PROD_W-1] ? vpf_pkg::GAIN_ROUND : '0);
        w_shift = w_tbias >>> vpf_pkg::GAIN_FRAC_BITS;
        priority if (w_shift > DRIVE_MAX) begin
            w_drive = DRIVE_MAX[vpf_pkg::DRIVE_W-1:0];
        end else if (w_shift < DRIVE_MIN) begin
            w_drive = DRIVE_MIN[vpf_pkg::DRIVE_W-1:0];
        end else begin
            w_drive = w_shift[vpf_pkg::DRIVE_W-1:0];
        end
    end

    // Sequencer: each sample passes through FILT, INTEG, IGAIN and SUM.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    n_state = ST_FILT;
                end
            end
            ST_FILT:  n_state = ST_INTEG;
            ST_INTEG: n_state = ST_IGAIN;
            ST_IGAIN: n_state = ST_SUM;
            ST_SUM: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = w_take ? ST_FILT : ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control state and the loop state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_filt      <= '0;
            r_integ     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == ST_FILT) begin
                r_filt <= w_filt;
            end
            // The tilt check follows the drive, so it only affects the next sample.
            if (r_state == ST_INTEG) begin
                r_integ <= r_roll_out ? '0 : w_iclamp;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_p_new    <= w_p_new;
            r_p_old    <= w_p_old;
            r_roll_out <= i_job.roll_out;
        end
        if (r_state == ST_INTEG) begin
            r_ival  <= w_iclamp;
            r_pprod <= $signed({1'b0, i_cfg.prop_gain}) * r_filt;
        end
        if (r_state == ST_IGAIN) begin
            r_iprod <= $signed({1'b0, i_cfg.integ_gain}) * r_ival;
        end
        if (w_load_out) begin
            r_drive <= w_drive;
        end
    end

endmodule

`default_nettype wire

// ===== sv/vpf_monitor.sv =====
// Port-level checks for the velocity PI loop, bound to the top level.
// Depends on velocity_pi_with_filtered_error_defines.svh for the macros.
`timescale 1ns / 1ps
`default_nettype none
`include "velocity_pi_with_filtered_error_defines.svh"

module vpf_monitor (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_in_stall,
    input  wire logic        o_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [23:0] o_drive_out
);

    // A stalled result stays offered.
    `VPF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result dropped while stalled")

    // A stalled result keeps its value.
    `VPF_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_drive_out), "result changed while stalled")

    // Reset empties the output register.
    `VPF_ASSERT_NEXT_ALWAYS(a_rst_out, i_clk, !i_rst_n, !o_out_valid, "result offered after reset")

    // Reset empties the queue, so the input side is open.
    `VPF_ASSERT_NEXT_ALWAYS(a_rst_in, i_clk, !i_rst_n, !o_in_stall, "input stalled after reset")

endmodule

bind velocity_pi_with_filtered_error vpf_monitor u_vpf_monitor (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_drive_out (o_drive_out)
);

`default_nettype wire

// ===== test/velocity_pi_with_filtered_error_test.sv =====
// Self-checking testbench for the velocity PI loop with a filtered error.
// Depends on vpf_pkg and velocity_pi_with_filtered_error; predicts every drive value
// from the accepted samples and register writes and compares it with the block.
`timescale 1ns / 1ps

module velocity_pi_with_filtered_error_test;
    import vpf_pkg::*;

    localparam int     CYCLE_LIMIT  = 400000;
    localparam int     DRAIN_CYCLES = 12;
    localparam int     SEGMENTS     = 7;
    localparam int     SEGMENT_LEN  = 200;
    localparam longint NEW_WEIGHT   = 13107;
    localparam longint OLD_WEIGHT   = 52429;
    localparam longint FILTER_SCALE = 65536;
    localparam longint DRIVE_HIGH   = 8388607;
    localparam longint DRIVE_LOW    = -8388608;

    // Tracks the loop state and the registers, and holds the drive values still owed.
    class drive_scoreboard;
        logic [GAIN_W-1:0]          prop_gain;
        logic [GAIN_W-1:0]          integ_gain;
        logic [LIMIT_W-1:0]         integral_limit;
        logic [TILT_W-1:0]          tilt_limit;
        logic signed [ERR_W-1:0]    filt_state;
        logic signed [INTEG_W-1:0]  integ_state;
        logic signed [DRIVE_W-1:0]  owed_drives[$];
        int                         fail_count;

        function new();
            prop_gain      = PROP_GAIN_RST;
            integ_gain     = INTEG_GAIN_RST;
            integral_limit = INTEGRAL_LIMIT_RST;
            tilt_limit     = TILT_LIMIT_RST;
            filt_state     = '0;
            integ_state    = '0;
            fail_count     = 0;
        endfunction

        // Each register keeps only the bits of its own width.
        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                CFG_PROP_GAIN:      prop_gain      = data[GAIN_W-1:0];
                CFG_INTEG_GAIN:     integ_gain     = data[GAIN_W-1:0];
                CFG_INTEGRAL_LIMIT: integral_limit = data[LIMIT_W-1:0];
                CFG_TILT_LIMIT:     tilt_limit     = data[TILT_W-1:0];
                default: ;
            endcase
        endfunction

        // Advances the loop by one sample and queues the drive it produces.
        function void note_sample(logic signed [SPEED_W-1:0] left,
                                  logic signed [SPEED_W-1:0] right,
                                  logic signed [SPEED_W-1:0] target,
                                  logic signed [ROLL_W-1:0]  roll);
            longint err, filt, sum, lim, drive;
            err  = longint'(left) + longint'(right) - longint'(target);
            // Signed division truncates toward zero, as the filter does.
            filt = (NEW_WEIGHT * err + OLD_WEIGHT * longint'(filt_state)) / FILTER_SCALE;
            filt_state = filt[ERR_W-1:0];

            lim = longint'(integral_limit);
            sum = longint'(integ_state) + filt;
            if (sum > lim)
                sum = lim;
            if (sum < -lim)
                sum = -lim;
            integ_state = sum[INTEG_W-1:0];

            drive = (longint'(prop_gain) * filt + longint'(integ_gain) * sum)
                    / (longint'(1) << GAIN_FRAC_BITS);
            if (drive > DRIVE_HIGH)
                drive = DRIVE_HIGH;
            if (drive < DRIVE_LOW)
                drive = DRIVE_LOW;

            // A roll past the tilt limit clears the integral for the next sample.
            if (longint'(roll) < -longint'(tilt_limit) || longint'(roll) > longint'(tilt_limit))
                integ_state = '0;

            owed_drives.push_back(drive[DRIVE_W-1:0]);
        endfunction

        function void check_drive(logic signed [DRIVE_W-1:0] actual);
            logic signed [DRIVE_W-1:0] wanted;
            if (owed_drives.size() == 0) begin
                $error("drive_out: expected none, actual %0d", actual);
                fail_count++;
            end else begin
                wanted = owed_drives.pop_front();
                if (actual !== wanted) begin
                    $error("drive_out: expected %0d, actual %0d", wanted, actual);
                    fail_count++;
                end
            end
        endfunction

        function int pending();
            return owed_drives.size();
        endfunction
    endclass

    logic                        i_clk          = 1'b0;
    logic                        i_rst_n        = 1'b0;
    logic                        i_in_valid     = 1'b0;
    logic                        o_in_stall;
    logic signed [SPEED_W-1:0]   i_left_speed   = '0;
    logic signed [SPEED_W-1:0]   i_right_speed  = '0;
    logic signed [SPEED_W-1:0]   i_target_speed = '0;
    logic signed [ROLL_W-1:0]    i_roll_tenths  = '0;
    logic                        o_out_valid;
    logic                        i_out_stall    = 1'b0;
    logic signed [DRIVE_W-1:0]   o_drive_out;
    logic                        i_cfg_valid    = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index    = '0;
    logic [CFG_DAT_W-1:0]        i_cfg_data     = '0;

    int              send_idle_pct = 17;
    int              recv_idle_pct = 54;
    int              cycle_count   = 0;
    drive_scoreboard sb            = new();

    velocity_pi_with_filtered_error DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_left_speed   (i_left_speed),
        .i_right_speed  (i_right_speed),
        .i_target_speed (i_target_speed),
        .i_roll_tenths  (i_roll_tenths),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_drive_out    (o_drive_out),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // The receiver stalls at random, at the rate of the current phase.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Every transfer on the three channels is observed here, with pre-edge values.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                sb.check_drive(o_drive_out);
            if (i_in_valid && !o_in_stall)
                sb.note_sample(i_left_speed, i_right_speed, i_target_speed, i_roll_tenths);
            if (i_cfg_valid && o_cfg_ready)
                sb.write_register(i_cfg_index, i_cfg_data);
        end
    end

    // Watchdog on the whole run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Presents one sample after a random gap and holds it until its transfer.
    task automatic send_sample(input logic signed [SPEED_W-1:0] left,
                               input logic signed [SPEED_W-1:0] right,
                               input logic signed [SPEED_W-1:0] target,
                               input logic signed [ROLL_W-1:0]  roll);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_left_speed   <= left;
        i_right_speed  <= right;
        i_target_speed <= target;
        i_roll_tenths  <= roll;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Writes all four registers back to back.
    task automatic apply_settings(input logic [CFG_DAT_W-1:0] pg, input logic [CFG_DAT_W-1:0] ig,
                                  input logic [CFG_DAT_W-1:0] lim,
                                  input logic [CFG_DAT_W-1:0] tilt);
        logic [CFG_DAT_W-1:0] values [4];
        logic [CFG_IDX_W-1:0] regs [4];
        values = '{pg, ig, lim, tilt};
        regs   = '{CFG_PROP_GAIN, CFG_INTEG_GAIN, CFG_INTEGRAL_LIMIT, CFG_TILT_LIMIT};
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[k];
            i_cfg_data  <= values[k];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Stops the input and waits until every owed drive has arrived.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        // Waiting past the current edge lets a transfer at that edge reach the scoreboard.
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [CFG_DAT_W-1:0] random_gain();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            2:       return CFG_DAT_W'($urandom_range(1 << 21));
            default: return CFG_DAT_W'($urandom);
        endcase
    endfunction

    // Sometimes sets bits above the register width, which the block must drop.
    function automatic logic [CFG_DAT_W-1:0] with_junk(logic [CFG_DAT_W-1:0] v, int w);
        if ($urandom_range(3) == 0)
            return v | (CFG_DAT_W'($urandom) << w);
        return v;
    endfunction

    // Mostly runs of steady wheel speeds with jitter, so the integral builds up;
    // the rest is noise over the whole field range.
    task automatic drive_random(input int count);
        int                        run_left;
        int                        kind;
        int                        tilt;
        logic signed [SPEED_W-1:0] base_l, base_r, base_t;
        logic signed [ROLL_W-1:0]  roll;
        run_left = 0;
        kind     = 0;
        base_l   = '0;
        base_r   = '0;
        base_t   = '0;
        tilt     = int'(sb.tilt_limit);
        for (int n = 0; n < count; n++) begin
            if (run_left == 0) begin
                run_left = $urandom_range(40, 4);
                kind     = $urandom_range(9);
                if ($urandom_range(1)) begin
                    base_l = SPEED_W'($urandom);
                    base_r = SPEED_W'($urandom);
                    base_t = SPEED_W'($urandom);
                end else begin
                    base_l = SPEED_W'($urandom_range(1024)) - SPEED_W'(512);
                    base_r = SPEED_W'($urandom_range(1024)) - SPEED_W'(512);
                    base_t = SPEED_W'($urandom_range(2048)) - SPEED_W'(1024);
                end
            end
            run_left--;
            // Rolls stay inside the tilt window most of the time.
            if ($urandom_range(99) < 15)
                roll = ROLL_W'($urandom);
            else
                roll = ROLL_W'($urandom_range(2 * tilt) - tilt);
            if (kind < 8)
                send_sample(base_l ^ SPEED_W'($urandom_range(15)),
                            base_r ^ SPEED_W'($urandom_range(15)),
                            base_t ^ SPEED_W'($urandom_range(7)), roll);
            else
                send_sample(SPEED_W'($urandom), SPEED_W'($urandom), SPEED_W'($urandom), roll);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: zero input, full-scale errors, rolls at and past the tilt limit.
        send_sample(16'sd0, 16'sd0, 16'sd0, 12'sd0);
        send_sample(16'sd32767, 16'sd32767, -16'sd32768, 12'sd0);
        send_sample(16'sd32767, 16'sd32767, -16'sd32768, 12'sd0);
        send_sample(-16'sd32768, -16'sd32768, 16'sd32767, 12'sd400);
        send_sample(-16'sd32768, -16'sd32768, 16'sd32767, 12'sd401);
        send_sample(16'sd0, 16'sd0, 16'sd0, -12'sd400);
        send_sample(16'sd0, 16'sd0, 16'sd0, -12'sd401);
        send_sample(16'sd100, 16'sd100, 16'sd0, 12'sd1800);
        send_sample(16'sd100, 16'sd100, 16'sd0, -12'sd1800);
        send_sample(16'sd100, 16'sd100, 16'sd0, 12'sd2047);
        send_sample(16'sd100, 16'sd100, 16'sd0, -12'sd2048);
        wait_drained();

        // Largest gains and integral limit drive the output as far as it goes.
        apply_settings('1, '1, CFG_DAT_W'(32767), CFG_DAT_W'(1800));
        for (int k = 0; k < 6; k++)
            send_sample(16'sd32767, 16'sd32767, -16'sd32768, 12'sd1800);
        send_sample(-16'sd32768, -16'sd32768, 16'sd32767, -12'sd1800);
        send_sample(-16'sd32768, -16'sd32768, 16'sd32767, -12'sd1801);
        wait_drained();

        // Zero gains, a zero integral limit and a zero tilt limit.
        apply_settings('0, '0, '0, '0);
        send_sample(16'sd5, 16'sd5, 16'sd0, 12'sd1);
        send_sample(16'sd5, 16'sd5, 16'sd0, 12'sd0);
        send_sample(-16'sd1, -16'sd1, 16'sd32767, -12'sd1);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 3) begin
                send_idle_pct = 54;
                recv_idle_pct = 17;
            end
            if (seg == 5) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_drained();
            case (seg)
                0: apply_settings(PROP_GAIN_RST, INTEG_GAIN_RST, INTEGRAL_LIMIT_RST,
                                  TILT_LIMIT_RST);
                2: apply_settings('1, '1, '1, '1);
                3: apply_settings('0, '1, CFG_DAT_W'($urandom_range(50)), '0);
                5: apply_settings(random_gain(), random_gain(), '0,
                                  with_junk(CFG_DAT_W'($urandom_range(1800)), TILT_W));
                default: apply_settings(random_gain(), random_gain(),
                                        with_junk(CFG_DAT_W'($urandom_range(32767)), LIMIT_W),
                                        with_junk(CFG_DAT_W'($urandom_range(1800)), TILT_W));
            endcase
            drive_random(SEGMENT_LEN);
        end
        wait_drained();

        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
